/* hw/rtl/mwm_pkg.sv */
// Shared types, constants and register indexes for the mecanum wheel mixer.
package mwm_pkg;

    localparam int WHEEL_COUNT = 4;
    localparam int AXIS_W      = 16;
    localparam int MIX_W       = 18;   // |sum of three axes| <= 98304
    localparam int MAG_W       = 17;
    localparam int Q_W         = 16;   // normalized magnitude <= 32768
    localparam int GAIN_W      = 16;
    localparam int PROD_W      = Q_W + GAIN_W;
    localparam int GAIN_SHIFT  = 14;
    localparam int DZ_W        = 15;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STEPS   = Q_W;  // one quotient bit per stage

    localparam logic [MAG_W-1:0]  ONE_Q15        = 17'd32768;
    localparam logic [DZ_W-1:0]   SAT_MAX        = 15'h7FFF;
    localparam logic [DZ_W-1:0]   DEAD_ZONE_RST  = 15'd3277;
    localparam logic [3:0]        INVERT_RST     = 4'd0;
    localparam logic [GAIN_W-1:0] GAIN_RST       = 16'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEAD_ZONE   = 3'd0,
        REG_INVERT_MASK = 3'd1,
        REG_GAIN_FL     = 3'd2,
        REG_GAIN_FR     = 3'd3,
        REG_GAIN_RL     = 3'd4,
        REG_GAIN_RR     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [AXIS_W-1:0] strafe;
        logic signed [AXIS_W-1:0] forward;
        logic signed [AXIS_W-1:0] rotate;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] front_left_speed;
        logic signed [15:0] front_right_speed;
        logic signed [15:0] rear_left_speed;
        logic signed [15:0] rear_right_speed;
        logic               idle;
    } result_t;

    typedef struct packed {
        logic [DZ_W-1:0]                     dead_zone;
        logic [WHEEL_COUNT-1:0]              invert_mask;
        logic [WHEEL_COUNT-1:0][GAIN_W-1:0]  gain;
    } cfg_t;

    // One divider stage: partial remainder plus the combined
    // dividend-bits / quotient-bits shift word per wheel.
    typedef struct packed {
        logic                                idle;
        logic [WHEEL_COUNT-1:0]              neg;
        logic [MAG_W-1:0]                    divisor;
        logic [WHEEL_COUNT-1:0][MAG_W-1:0]   rem;
        logic [WHEEL_COUNT-1:0][Q_W-1:0]     nq;
    } div_t;

endpackage

/* hw/rtl/mwm_front.sv */
// Front end: dead zone test, wheel mixing, magnitudes and divisor select.
module mwm_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  mwm_pkg::cmd_t               cmd,
    input  logic [mwm_pkg::DZ_W-1:0]    dead_zone,
    output logic                        out_valid,
    output mwm_pkg::div_t               out_beat
);

    localparam int WC = mwm_pkg::WHEEL_COUNT;
    localparam int MW = mwm_pkg::MIX_W;
    localparam int AW = mwm_pkg::MAG_W;

    // stage A: mix
    logic                    valid_a_reg;
    logic                    idle_a_reg, idle_a_next;
    logic [WC-1:0][MW-1:0]   mix_a_reg, mix_a_next;
    // stage B: magnitudes
    logic                    valid_b_reg;
    logic                    idle_b_reg;
    logic [WC-1:0]           neg_b_reg, neg_b_next;
    logic [WC-1:0][AW-1:0]   mag_b_reg, mag_b_next;
    // stage C: divider setup
    logic                    valid_c_reg;
    mwm_pkg::div_t           div_c_reg, div_c_next;

    logic [AW-1:0] ext_s, ext_f, ext_r;
    logic [AW-1:0] mag_s, mag_f, mag_r;
    logic [MW-1:0] x18, y18, r18;

    always_comb
    begin
        ext_s = {cmd.strafe[15], cmd.strafe};
        ext_f = {cmd.forward[15], cmd.forward};
        ext_r = {cmd.rotate[15], cmd.rotate};
        mag_s = cmd.strafe[15]  ? -ext_s : ext_s;
        mag_f = cmd.forward[15] ? -ext_f : ext_f;
        mag_r = cmd.rotate[15]  ? -ext_r : ext_r;
        idle_a_next = (mag_s < {2'b00, dead_zone}) && (mag_f < {2'b00, dead_zone})
                   && (mag_r < {2'b00, dead_zone});

        x18 = {{2{cmd.strafe[15]}}, cmd.strafe};
        y18 = -{{2{cmd.forward[15]}}, cmd.forward};
        r18 = {{2{cmd.rotate[15]}}, cmd.rotate};
        mix_a_next[0] =  x18 + y18 + r18;
        mix_a_next[1] = -x18 + y18 - r18;
        mix_a_next[2] = -x18 + y18 + r18;
        mix_a_next[3] =  x18 + y18 - r18;
    end

    logic [MW-1:0] neg_mix [WC];

    always_comb
    begin
        for (int w = 0; w < WC; w++)
        begin
            neg_mix[w]    = -mix_a_reg[w];
            neg_b_next[w] = mix_a_reg[w][MW-1];
            mag_b_next[w] = mix_a_reg[w][MW-1] ? neg_mix[w][AW-1:0] : mix_a_reg[w][AW-1:0];
        end
    end

    logic [AW-1:0] max01, max23, max_all;

    always_comb
    begin
        max01   = (mag_b_reg[0] > mag_b_reg[1]) ? mag_b_reg[0] : mag_b_reg[1];
        max23   = (mag_b_reg[2] > mag_b_reg[3]) ? mag_b_reg[2] : mag_b_reg[3];
        max_all = (max01 > max23) ? max01 : max23;
        div_c_next.idle    = idle_b_reg;
        div_c_next.neg     = neg_b_reg;
        // below 1.0 a divide by 1.0 passes the magnitude through unchanged
        div_c_next.divisor = (max_all > mwm_pkg::ONE_Q15) ? max_all : mwm_pkg::ONE_Q15;
        for (int w = 0; w < WC; w++)
        begin
            div_c_next.rem[w] = {1'b0, mag_b_reg[w][AW-1:1]};
            div_c_next.nq[w]  = {mag_b_reg[w][0], {(mwm_pkg::Q_W-1){1'b0}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idle_a_reg <= idle_a_next;
        mix_a_reg  <= mix_a_next;
        idle_b_reg <= idle_a_reg;
        neg_b_reg  <= neg_b_next;
        mag_b_reg  <= mag_b_next;
        div_c_reg  <= div_c_next;
    end

    assign out_valid = valid_c_reg;
    assign out_beat  = div_c_reg;

endmodule

/* hw/rtl/mwm_div.sv */
// Pipelined restoring divider, one quotient bit per stage, four wheels in parallel.
module mwm_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  mwm_pkg::div_t in_beat,
    output logic          out_valid,
    output mwm_pkg::div_t out_beat
);

    localparam int WC = mwm_pkg::WHEEL_COUNT;
    localparam int NS = mwm_pkg::DIV_STEPS;
    localparam int AW = mwm_pkg::MAG_W;
    localparam int QW = mwm_pkg::Q_W;

    mwm_pkg::div_t chain_reg   [NS+1];
    logic          chain_valid [NS+1];

    assign chain_reg[0]   = in_beat;
    assign chain_valid[0] = in_valid;

    for (genvar s = 0; s < NS; s++)
    begin : g_step
        mwm_pkg::div_t           step_next;
        logic [WC-1:0][AW:0]     trial;
        logic [AW:0]             diff [WC];
        logic                    valid_reg;
        mwm_pkg::div_t           step_reg;

        always_comb
        begin
            step_next = chain_reg[s];
            for (int w = 0; w < WC; w++)
            begin
                trial[w] = {chain_reg[s].rem[w], chain_reg[s].nq[w][QW-1]};
                diff[w]  = trial[w] - {1'b0, chain_reg[s].divisor};
                if (trial[w] >= {1'b0, chain_reg[s].divisor})
                begin
                    step_next.rem[w] = diff[w][AW-1:0];
                    step_next.nq[w]  = {chain_reg[s].nq[w][QW-2:0], 1'b1};
                end
                else
                begin
                    step_next.rem[w] = trial[w][AW-1:0];
                    step_next.nq[w]  = {chain_reg[s].nq[w][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg <= 1'b0;
            end
            else
            begin
                valid_reg <= chain_valid[s];
            end
        end

        always_ff @(posedge clk)
        begin
            step_reg <= step_next;
        end

        assign chain_reg[s+1]   = step_reg;
        assign chain_valid[s+1] = valid_reg;
    end

    assign out_valid = chain_valid[NS];
    assign out_beat  = chain_reg[NS];

endmodule

/* hw/rtl/mwm_scale.sv */
// Back end: per-wheel gain multiply, sign, saturation and result register.
module mwm_scale (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  mwm_pkg::div_t    in_beat,
    input  mwm_pkg::cfg_t    cfg,
    output logic             done,
    output mwm_pkg::result_t result
);

    localparam int WC = mwm_pkg::WHEEL_COUNT;
    localparam int PW = mwm_pkg::PROD_W;
    localparam int GS = mwm_pkg::GAIN_SHIFT;

    // stage M: multiply
    logic                  valid_m_reg;
    logic                  idle_m_reg;
    logic [WC-1:0]         neg_m_reg, neg_m_next;
    logic [WC-1:0][PW-1:0] prod_m_reg, prod_m_next;
    // stage O: output
    logic                  done_reg;
    mwm_pkg::result_t      result_reg, result_next;

    always_comb
    begin
        for (int w = 0; w < WC; w++)
        begin
            prod_m_next[w] = PW'(in_beat.nq[w]) * PW'(cfg.gain[w]);
            neg_m_next[w]  = in_beat.neg[w] ^ cfg.invert_mask[w];
        end
    end

    logic [PW-GS-1:0]        shifted [WC];
    logic [15:0]             mag16   [WC];
    logic [WC-1:0][15:0]     speed;

    always_comb
    begin
        for (int w = 0; w < WC; w++)
        begin
            shifted[w] = prod_m_reg[w][PW-1:GS];
            mag16[w]   = (shifted[w] > (PW-GS)'(mwm_pkg::SAT_MAX))
                         ? {1'b0, mwm_pkg::SAT_MAX} : {1'b0, shifted[w][14:0]};
            if (idle_m_reg)
            begin
                speed[w] = 16'd0;
            end
            else
            begin
                speed[w] = neg_m_reg[w] ? -mag16[w] : mag16[w];
            end
        end
        result_next.front_left_speed  = speed[0];
        result_next.front_right_speed = speed[1];
        result_next.rear_left_speed   = speed[2];
        result_next.rear_right_speed  = speed[3];
        result_next.idle              = idle_m_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_m_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            valid_m_reg <= in_valid;
            done_reg    <= valid_m_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        idle_m_reg <= in_beat.idle;
        neg_m_reg  <= neg_m_next;
        prod_m_reg <= prod_m_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hw/rtl/mecanum_wheel_mixer_top.sv */
// Top level of the mecanum wheel mixer: configuration registers and pipeline.
//
// Mecanum wheel mixer. Each beat on cmd (strafe, forward, rotate in Q1.15) is
// taken when start is high; busy never rises, so a new command set may be
// issued in every cycle. The four wheel speeds and the idle flag then appear
// on result with done high for one cycle. The receiver cannot stall: it must
// take each result beat in the cycle it is shown. The result is produced by
// the pipeline: three front stages (dead zone test and mixing, magnitudes,
// maximum and divisor), a sixteen-stage restoring divider that produces one
// quotient bit per stage for all four wheels at once, and two back stages
// (gain multiply, then saturation and sign), 21 register stages in all.
// Configuration writes through cfg_write / cfg_index / cfg_data take effect
// at the next edge and must only be made while no command is in flight;
// indexes six and seven are ignored.
module mecanum_wheel_mixer_top (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  mwm_pkg::cmd_t                     cmd,
    output logic                              done,
    output mwm_pkg::result_t                  result,
    input  logic                              cfg_write,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mwm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    mwm_pkg::cfg_t cfg_reg;

    // Register file; writes outside the map fall through the default arm.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dead_zone   <= mwm_pkg::DEAD_ZONE_RST;
            cfg_reg.invert_mask <= mwm_pkg::INVERT_RST;
            for (int w = 0; w < mwm_pkg::WHEEL_COUNT; w++)
            begin
                cfg_reg.gain[w] <= mwm_pkg::GAIN_RST;
            end
        end
        else if (cfg_write)
        begin
            unique case (mwm_pkg::cfg_reg_t'(cfg_index))
                mwm_pkg::REG_DEAD_ZONE:   cfg_reg.dead_zone   <= cfg_data[mwm_pkg::DZ_W-1:0];
                mwm_pkg::REG_INVERT_MASK: cfg_reg.invert_mask <= cfg_data[3:0];
                mwm_pkg::REG_GAIN_FL:     cfg_reg.gain[0]     <= cfg_data;
                mwm_pkg::REG_GAIN_FR:     cfg_reg.gain[1]     <= cfg_data;
                mwm_pkg::REG_GAIN_RL:     cfg_reg.gain[2]     <= cfg_data;
                mwm_pkg::REG_GAIN_RR:     cfg_reg.gain[3]     <= cfg_data;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    // Fully pipelined: never back-pressures the command side.
    assign busy = 1'b0;

    logic          front_valid;
    mwm_pkg::div_t front_beat;
    logic          div_valid;
    mwm_pkg::div_t div_beat;

    mwm_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start),
        .cmd       (cmd),
        .dead_zone (cfg_reg.dead_zone),
        .out_valid (front_valid),
        .out_beat  (front_beat)
    );

    // Normalize: magnitude * 1.0 / max(largest magnitude, 1.0).
    mwm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_beat   (front_beat),
        .out_valid (div_valid),
        .out_beat  (div_beat)
    );

    mwm_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (div_valid),
        .in_beat  (div_beat),
        .cfg      (cfg_reg),
        .done     (done),
        .result   (result)
    );

endmodule

/* test/tb.sv */
// Testbench for the mecanum wheel mixer: directed table and random commands against a local model.
`timescale 1ns / 1ps

module tb;

    localparam int WHEEL_COUNT = mwm_pkg::WHEEL_COUNT;
    localparam int AXIS_W      = mwm_pkg::AXIS_W;
    localparam int MIX_W       = mwm_pkg::MIX_W;
    localparam int MAG_W       = mwm_pkg::MAG_W;
    localparam int PROD_W      = mwm_pkg::PROD_W;
    localparam int GAIN_SHIFT  = mwm_pkg::GAIN_SHIFT;
    localparam int DZ_W        = mwm_pkg::DZ_W;
    localparam int GAIN_W      = mwm_pkg::GAIN_W;
    localparam int CFG_IDX_W   = mwm_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W  = mwm_pkg::CFG_DATA_W;

    // Pipeline depth from accepting edge to done.
    localparam int PIPE_LATENCY = 20;
    localparam int RANDOM_PER_PHASE = 200;
    localparam int N_DIRECTED = 22;

    // Indexes past the last register; the block must ignore writes to them.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    mwm_pkg::cmd_t         cmd = '0;
    logic                  done;
    mwm_pkg::result_t      result;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mecanum_wheel_mixer_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the register file, kept at the register widths.
    logic [DZ_W-1:0]          dz_q = mwm_pkg::DEAD_ZONE_RST;
    logic [WHEEL_COUNT-1:0]   inv_q = mwm_pkg::INVERT_RST;
    logic [GAIN_W-1:0]        gain_q [WHEEL_COUNT] = '{mwm_pkg::GAIN_RST, mwm_pkg::GAIN_RST,
                                                       mwm_pkg::GAIN_RST, mwm_pkg::GAIN_RST};

    // Wheel results still owed by the pipeline, oldest first.
    mwm_pkg::result_t expected_speeds [$];
    int               mismatches = 0;
    mwm_pkg::result_t head;

    // One row of the directed table. When known is set, the wheel values
    // below are the answer under reset configuration; otherwise the model
    // predicts it.
    typedef struct {
        int sx;
        int fw;
        int rt;
        bit known;
        int fl;
        int fr;
        int rl;
        int rr;
        bit idle;
    } row_t;

    row_t directed_rows [N_DIRECTED] = '{
        // everything at rest
        '{0, 0, 0,                1, 0, 0, 0, 0, 1},
        // one count inside the default dead zone, single axis and all three
        '{3276, 0, 0,             1, 0, 0, 0, 0, 1},
        '{-3276, 3276, -3276,     1, 0, 0, 0, 0, 1},
        // first value out of the dead zone on each axis
        '{3277, 0, 0,             1, 3277, -3277, -3277, 3277, 0},
        '{0, -3277, 0,            1, 3277, 3277, 3277, 3277, 0},
        '{0, 0, -3277,            1, -3277, 3277, -3277, 3277, 0},
        // full-scale single axes; magnitude 32768 saturates to 32767
        '{-32768, 0, 0,           1, -32767, 32767, 32767, -32767, 0},
        '{32767, 0, 0,            1, 32767, -32767, -32767, 32767, 0},
        '{0, 32767, 0,            1, -32767, -32767, -32767, -32767, 0},
        '{0, -32768, 0,           1, 32767, 32767, 32767, 32767, 0},
        '{0, 0, 32767,            1, 32767, -32767, 32767, -32767, 0},
        '{0, 0, -32768,           1, -32767, 32767, -32767, 32767, 0},
        // peak exactly 1.0: no normalization
        '{16384, -16384, 0,       1, 32767, 0, 0, 32767, 0},
        // normalization cases, then two model-predicted sets that need none
        '{16384, -16384, 1,       0, 0, 0, 0, 0, 0},
        '{32767, 32767, 32767,    0, 0, 0, 0, 0, 0},
        '{-32768, -32768, -32768, 0, 0, 0, 0, 0, 0},
        '{-32768, 32767, -32768,  0, 0, 0, 0, 0, 0},
        '{32767, -32768, 32767,   0, 0, 0, 0, 0, 0},
        '{12345, -23456, 7890,    0, 0, 0, 0, 0, 0},
        '{-21846, 21845, 10923,   0, 0, 0, 0, 0, 0},
        '{-1, 1, -1,              0, 0, 0, 0, 0, 0},
        '{0, 0, 3277,             0, 0, 0, 0, 0, 0}
    };

    function automatic logic [MAG_W-1:0] axis_mag(logic signed [MIX_W-1:0] v);
        return (v < 0) ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // Wheel speeds for one command set under the shadow configuration.
    function automatic mwm_pkg::result_t wheel_speeds(mwm_pkg::cmd_t c);
        logic signed [MIX_W-1:0] sx;
        logic signed [MIX_W-1:0] fy;
        logic signed [MIX_W-1:0] rz;
        logic signed [MIX_W-1:0] mix [WHEEL_COUNT];
        logic [MAG_W-1:0]        peak;
        logic [PROD_W+1:0]       m;
        logic [PROD_W+1:0]       prod;
        logic [15:0]             spd [WHEEL_COUNT];
        logic                    neg;
        mwm_pkg::result_t        res;

        sx = {{(MIX_W-AXIS_W){c.strafe[AXIS_W-1]}}, c.strafe};
        fy = -$signed({{(MIX_W-AXIS_W){c.forward[AXIS_W-1]}}, c.forward});
        rz = {{(MIX_W-AXIS_W){c.rotate[AXIS_W-1]}}, c.rotate};

        res = '0;
        if (axis_mag(sx) < MAG_W'(dz_q) && axis_mag(fy) < MAG_W'(dz_q) &&
            axis_mag(rz) < MAG_W'(dz_q))
        begin
            res.idle = 1'b1;
            return res;
        end

        mix[0] = sx + fy + rz;
        mix[1] = -sx + fy - rz;
        mix[2] = -sx + fy + rz;
        mix[3] = sx + fy - rz;

        peak = '0;
        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            if (axis_mag(mix[i]) > peak)
                peak = axis_mag(mix[i]);
        end

        for (int i = 0; i < WHEEL_COUNT; i++)
        begin
            m = axis_mag(mix[i]);
            // scale all wheels down by the peak when it is above 1.0, truncating
            if (peak > mwm_pkg::ONE_Q15)
                m = (m * mwm_pkg::ONE_Q15) / peak;
            neg  = mix[i][MIX_W-1] ^ inv_q[i];
            prod = (m * gain_q[i]) >> GAIN_SHIFT;
            if (prod > mwm_pkg::SAT_MAX)
                prod = mwm_pkg::SAT_MAX;
            spd[i] = neg ? -prod[15:0] : prod[15:0];
        end

        res.front_left_speed  = spd[0];
        res.front_right_speed = spd[1];
        res.rear_left_speed   = spd[2];
        res.rear_right_speed  = spd[3];
        return res;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(string name, logic signed [15:0] got, logic signed [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
    endtask

    // Result side: done is a one-cycle strobe, so every beat is taken as shown.
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_speeds.size() == 0)
                report_mismatch("result beat with no command outstanding");
            else
            begin
                head = expected_speeds.pop_front();
                check_field("front_left_speed", result.front_left_speed, head.front_left_speed);
                check_field("front_right_speed", result.front_right_speed,
                            head.front_right_speed);
                check_field("rear_left_speed", result.rear_left_speed, head.rear_left_speed);
                check_field("rear_right_speed", result.rear_right_speed, head.rear_right_speed);
                check_field("idle", {15'd0, result.idle}, {15'd0, head.idle});
            end
        end
    end

    // One register write; the block takes it at the edge that ends this cycle.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            mwm_pkg::REG_DEAD_ZONE:   dz_q = data[DZ_W-1:0];
            mwm_pkg::REG_INVERT_MASK: inv_q = data[WHEEL_COUNT-1:0];
            mwm_pkg::REG_GAIN_FL:     gain_q[0] = data;
            mwm_pkg::REG_GAIN_FR:     gain_q[1] = data;
            mwm_pkg::REG_GAIN_RL:     gain_q[2] = data;
            mwm_pkg::REG_GAIN_RR:     gain_q[3] = data;
            default: ;
        endcase
    endtask

    // Full register set, plus a stray write to an unused index.
    task automatic program_regs(logic [15:0] dz, logic [15:0] inv, logic [15:0] gfl,
                                logic [15:0] gfr, logic [15:0] grl, logic [15:0] grr);
        write_reg(mwm_pkg::REG_DEAD_ZONE, dz);
        write_reg(mwm_pkg::REG_INVERT_MASK, inv);
        write_reg(mwm_pkg::REG_GAIN_FL, gfl);
        write_reg(mwm_pkg::REG_GAIN_FR, gfr);
        write_reg(mwm_pkg::REG_GAIN_RL, grl);
        write_reg(mwm_pkg::REG_GAIN_RR, grr);
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 16'($urandom));
    endtask

    // Present one command beat after an optional gap and wait for the
    // accepting edge. start stays high if the next beat follows with no gap.
    task automatic send_cmd(mwm_pkg::cmd_t c, mwm_pkg::result_t want, int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            cmd   <= mwm_pkg::cmd_t'($urandom_range(0, 1) ? {$urandom, 16'($urandom)}
                                                          : 48'd0);
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
        expected_speeds.push_back(want);
    endtask

    // Wait out everything in flight, then the pipe depth for good measure.
    task automatic drain();
        start <= 1'b0;
        while (expected_speeds.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    // Axis value: quiet draws stay strictly inside a nonempty dead zone;
    // else a mix of extremes, values near the dead zone edge and raw noise.
    function automatic logic [15:0] random_axis(bit quiet);
        logic [15:0] v;
        int unsigned d;
        d = dz_q;
        if (quiet)
            v = (d == 0) ? 16'd0 : 16'($urandom_range(0, d - 1));
        else
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    case ($urandom_range(0, 3))
                        0:       v = 16'h8000;
                        1:       v = 16'h7FFF;
                        2:       v = 16'h8001;
                        default: v = 16'h0000;
                    endcase
                end
                1:       v = 16'(d + $urandom_range(0, 4) - 2);
                default: v = 16'($urandom);
            endcase
        end
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic [15:0] random_gain();
        case ($urandom_range(0, 3))
            0:       return mwm_pkg::GAIN_RST;
            1:       return 16'($urandom_range(0, 4));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_random(int count);
        mwm_pkg::cmd_t c;
        bit            quiet;
        bit            burst;
        int            gap;
        burst = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            // every 40 beats, maybe switch to back-to-back issue
            if (n % 40 == 0)
                burst = ($urandom_range(0, 2) == 0);
            gap = burst ? 0 : $urandom_range(0, 5);
            // about one set in eight is all-quiet so the idle path stays busy
            quiet = ($urandom_range(0, 7) == 0);
            c.strafe  = random_axis(quiet);
            c.forward = random_axis(quiet);
            c.rotate  = random_axis(quiet);
            send_cmd(c, wheel_speeds(c), gap);
        end
    endtask

    initial
    begin
        mwm_pkg::cmd_t    c;
        mwm_pkg::result_t want;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under reset configuration.
        foreach (directed_rows[i])
        begin
            c.strafe  = 16'(directed_rows[i].sx);
            c.forward = 16'(directed_rows[i].fw);
            c.rotate  = 16'(directed_rows[i].rt);
            if (directed_rows[i].known)
            begin
                want.front_left_speed  = 16'(directed_rows[i].fl);
                want.front_right_speed = 16'(directed_rows[i].fr);
                want.rear_left_speed   = 16'(directed_rows[i].rl);
                want.rear_right_speed  = 16'(directed_rows[i].rr);
                want.idle              = directed_rows[i].idle;
            end
            else
                want = wheel_speeds(c);
            send_cmd(c, want, $urandom_range(0, 5));
        end
        run_random(RANDOM_PER_PHASE);

        // No dead zone, every wheel inverted, maximum gain.
        drain();
        program_regs(16'h0000, 16'h000F, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(RANDOM_PER_PHASE);

        // Widest dead zone (top data bit dropped), junk above the mask, zero gain.
        drain();
        program_regs(16'hFFFF, 16'hFFF0, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        run_random(RANDOM_PER_PHASE);

        // Random settings, mostly modest dead zones.
        for (int p = 0; p < 5; p++)
        begin
            drain();
            program_regs(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                     : 16'($urandom_range(0, 8192)),
                         16'($urandom), random_gain(), random_gain(), random_gain(),
                         random_gain());
            run_random(RANDOM_PER_PHASE);
        end

        drain();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: well past the slowest legal run of 1622 command beats.
    initial
    begin
        #(2_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
